### rtl/core/owbm_pkg.sv
`default_nettype none

package owbm_pkg;

    // Tick counter width; the counter saturates at its all-ones value.
    localparam int COUNTER_BITS = 10;
    localparam int CFG_W        = 10;
    localparam int CFG_NUM      = 7;
    localparam int CMP_W        = (COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W;
    localparam int ADDR_W       = 5;

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_RESET_LOW     = 3'd0,
        REG_RESET_RELEASE = 3'd1,
        REG_PRESENCE      = 3'd2,
        REG_SLOT_START    = 3'd3,
        REG_WRITE_HOLD    = 3'd4,
        REG_READ_SAMPLE   = 3'd5,
        REG_READ_RECOVERY = 3'd6
    } reg_idx_t;

    localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd750;
    localparam logic [CFG_W-1:0] RST_RESET_RELEASE = 10'd15;
    localparam logic [CFG_W-1:0] RST_PRESENCE      = 10'd240;
    localparam logic [CFG_W-1:0] RST_SLOT_START    = 10'd2;
    localparam logic [CFG_W-1:0] RST_WRITE_HOLD    = 10'd60;
    localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 10'd10;
    localparam logic [CFG_W-1:0] RST_READ_RECOVERY = 10'd60;

    // Command codes carried in func.
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_RESET = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    // Operation status codes.
    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_NO_PRESENCE = 2'd1;
    localparam logic [1:0] STAT_NO_RELEASE  = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_ticks;
        logic [CFG_W-1:0] reset_release_ticks;
        logic [CFG_W-1:0] presence_limit;
        logic [CFG_W-1:0] slot_start_ticks;
        logic [CFG_W-1:0] write_hold_ticks;
        logic [CFG_W-1:0] read_sample_ticks;
        logic [CFG_W-1:0] read_recovery_ticks;
    } owbm_cfg_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] rx_byte;
    } owbm_res_t;

endpackage

`default_nettype wire

### rtl/core/owbm_ifs.sv
`default_nettype none

interface owbm_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] tx_byte;
    logic       bus_sample;

    modport source (output valid, output func, output tx_byte, output bus_sample,
                    input ready);
    modport sink   (input valid, input func, input tx_byte, input bus_sample,
                    output ready);
endinterface

interface owbm_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] rx_byte;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output status, output rx_byte, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input status, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/core/one_wire_bus_master.sv
// Channel  Role        Payload
// cmd      item in     func, tx_byte, bus_sample
// res      item out    drive_low, busy_res, done_res, status, rx_byte
// APB      config      seven 10-bit timing registers at byte address 4*i
//
// For each item the engine state is updated and the result is written
// into the output buffer at the same clock edge.
// One item per cycle is sustained while the output side is ready; a
// two-entry output buffer lets one further item in while a result is stalled.
// Reset (rst_n, asynchronous) returns the engine to idle and the registers
// to their default timings.
`default_nettype none

module one_wire_bus_master
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    owbm_cmd_if.sink                         cmd,
    owbm_res_if.source                       res,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [owbm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    owbm_pkg::owbm_cfg_t cfg;
    owbm_pkg::owbm_res_t eng_res;
    owbm_pkg::owbm_res_t buf_res;
    logic                accept;
    logic                can_push;

    assign cmd.ready = can_push;
    assign accept    = cmd.valid & can_push;

    owbm_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owbm_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .func       (cmd.func),
        .tx_byte    (cmd.tx_byte),
        .bus_sample (cmd.bus_sample),
        .cfg        (cfg),
        .res        (eng_res)
    );

    owbm_out_buf u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (eng_res),
        .can_push  (can_push),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_data  (buf_res)
    );

    assign res.drive_low = buf_res.drive_low;
    assign res.busy_res  = buf_res.busy_res;
    assign res.done_res  = buf_res.done_res;
    assign res.status    = buf_res.status;
    assign res.rx_byte   = buf_res.rx_byte;

endmodule

`default_nettype wire

### rtl/core/owbm_cfg_regs.sv
`default_nettype none

module owbm_cfg_regs
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [owbm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output owbm_pkg::owbm_cfg_t             cfg
);

    owbm_pkg::owbm_cfg_t cfg_reg;
    owbm_pkg::owbm_cfg_t cfg_next;
    logic [2:0]          idx;
    logic [owbm_pkg::CFG_W-1:0] wval;
    logic [owbm_pkg::CFG_W-1:0] rval;

    assign idx    = paddr[4:2];
    assign wval   = pwdata[owbm_pkg::CFG_W-1:0];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (idx)
                owbm_pkg::REG_RESET_LOW:     cfg_next.reset_low_ticks     = wval;
                owbm_pkg::REG_RESET_RELEASE: cfg_next.reset_release_ticks = wval;
                owbm_pkg::REG_PRESENCE:      cfg_next.presence_limit      = wval;
                owbm_pkg::REG_SLOT_START:    cfg_next.slot_start_ticks    = wval;
                owbm_pkg::REG_WRITE_HOLD:    cfg_next.write_hold_ticks    = wval;
                owbm_pkg::REG_READ_SAMPLE:   cfg_next.read_sample_ticks   = wval;
                owbm_pkg::REG_READ_RECOVERY: cfg_next.read_recovery_ticks = wval;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            owbm_pkg::REG_RESET_LOW:     rval = cfg_reg.reset_low_ticks;
            owbm_pkg::REG_RESET_RELEASE: rval = cfg_reg.reset_release_ticks;
            owbm_pkg::REG_PRESENCE:      rval = cfg_reg.presence_limit;
            owbm_pkg::REG_SLOT_START:    rval = cfg_reg.slot_start_ticks;
            owbm_pkg::REG_WRITE_HOLD:    rval = cfg_reg.write_hold_ticks;
            owbm_pkg::REG_READ_SAMPLE:   rval = cfg_reg.read_sample_ticks;
            owbm_pkg::REG_READ_RECOVERY: rval = cfg_reg.read_recovery_ticks;
            default:                     rval = '0;
        endcase
        prdata = 32'(rval);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_ticks     <= owbm_pkg::RST_RESET_LOW;
            cfg_reg.reset_release_ticks <= owbm_pkg::RST_RESET_RELEASE;
            cfg_reg.presence_limit      <= owbm_pkg::RST_PRESENCE;
            cfg_reg.slot_start_ticks    <= owbm_pkg::RST_SLOT_START;
            cfg_reg.write_hold_ticks    <= owbm_pkg::RST_WRITE_HOLD;
            cfg_reg.read_sample_ticks   <= owbm_pkg::RST_READ_SAMPLE;
            cfg_reg.read_recovery_ticks <= owbm_pkg::RST_READ_RECOVERY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/owbm_engine.sv
`default_nettype none

module owbm_engine
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [1:0]          func,
    input  wire logic [7:0]          tx_byte,
    input  wire logic                bus_sample,
    input  wire owbm_pkg::owbm_cfg_t cfg,
    output owbm_pkg::owbm_res_t      res
);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_RLOW   = 4'd1,
        PH_RREL   = 4'd2,
        PH_PLOW   = 4'd3,
        PH_PHIGH  = 4'd4,
        PH_WSTART = 4'd5,
        PH_WHOLD  = 4'd6,
        PH_WGAP   = 4'd7,
        PH_RSTART = 4'd8,
        PH_RWAIT  = 4'd9,
        PH_RREC   = 4'd10
    } phase_t;

    phase_t                           phase_reg, phase_next;
    logic [owbm_pkg::COUNTER_BITS-1:0] tick_reg, tick_next;
    logic [2:0]                       bit_reg, bit_next;
    logic [7:0]                       shift_reg, shift_next;
    logic [1:0]                       status_reg, status_next;
    logic [7:0]                       rx_reg, rx_next;
    logic                             done;

    logic [owbm_pkg::CFG_W-1:0]        lim;
    logic [owbm_pkg::COUNTER_BITS-1:0] cnt_inc;
    logic                             hit;

    // Limit of the current phase, and the counter step shared by all phases.
    always_comb
    begin
        case (phase_reg)
            PH_RLOW:                          lim = cfg.reset_low_ticks;
            PH_RREL:                          lim = cfg.reset_release_ticks;
            PH_PLOW, PH_PHIGH:                lim = cfg.presence_limit;
            PH_WHOLD:                         lim = cfg.write_hold_ticks;
            PH_RWAIT:                         lim = cfg.read_sample_ticks;
            PH_RREC:                          lim = cfg.read_recovery_ticks;
            default:                          lim = cfg.slot_start_ticks;
        endcase
        cnt_inc = (tick_reg == owbm_pkg::CNT_MAX) ? tick_reg : tick_reg + 1'b1;
        hit = (owbm_pkg::CMP_W'(cnt_inc) >= owbm_pkg::CMP_W'(lim)) ||
              (cnt_inc == owbm_pkg::CNT_MAX);
    end

    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        status_next = status_reg;
        rx_next     = rx_reg;
        done        = 1'b0;

        if (func == owbm_pkg::FUNC_TICK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                tick_next = hit ? '0 : cnt_inc;
                unique case (phase_reg)
                    PH_RLOW:
                    begin
                        if (hit) phase_next = PH_RREL;
                    end
                    PH_RREL:
                    begin
                        if (hit) phase_next = PH_PLOW;
                    end
                    PH_PLOW:
                    begin
                        if (!bus_sample)
                        begin
                            phase_next = PH_PHIGH;
                            tick_next  = '0;
                        end
                        else if (hit)
                        begin
                            status_next = owbm_pkg::STAT_NO_PRESENCE;
                            done        = 1'b1;
                            phase_next  = PH_IDLE;
                        end
                    end
                    PH_PHIGH:
                    begin
                        if (bus_sample)
                        begin
                            status_next = owbm_pkg::STAT_OK;
                            done        = 1'b1;
                            phase_next  = PH_IDLE;
                            tick_next   = '0;
                        end
                        else if (hit)
                        begin
                            status_next = owbm_pkg::STAT_NO_RELEASE;
                            done        = 1'b1;
                            phase_next  = PH_IDLE;
                        end
                    end
                    PH_WSTART:
                    begin
                        if (hit) phase_next = PH_WHOLD;
                    end
                    PH_WHOLD:
                    begin
                        if (hit) phase_next = PH_WGAP;
                    end
                    PH_WGAP:
                    begin
                        if (hit)
                        begin
                            shift_next = {1'b0, shift_reg[7:1]};
                            if (bit_reg == 3'd7)
                            begin
                                status_next = owbm_pkg::STAT_OK;
                                done        = 1'b1;
                                phase_next  = PH_IDLE;
                            end
                            else
                            begin
                                bit_next   = bit_reg + 3'd1;
                                phase_next = PH_WSTART;
                            end
                        end
                    end
                    PH_RSTART:
                    begin
                        if (hit) phase_next = PH_RWAIT;
                    end
                    PH_RWAIT:
                    begin
                        if (hit)
                        begin
                            shift_next = {bus_sample, shift_reg[7:1]};
                            phase_next = PH_RREC;
                        end
                    end
                    PH_RREC:
                    begin
                        if (hit)
                        begin
                            if (bit_reg == 3'd7)
                            begin
                                rx_next     = shift_reg;
                                status_next = owbm_pkg::STAT_OK;
                                done        = 1'b1;
                                phase_next  = PH_IDLE;
                            end
                            else
                            begin
                                bit_next   = bit_reg + 3'd1;
                                phase_next = PH_RSTART;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                    end
                endcase
            end
        end
        else if (phase_reg == PH_IDLE)
        begin
            // A command while an operation runs is dropped without effect.
            bit_next  = '0;
            tick_next = '0;
            unique case (func)
                owbm_pkg::FUNC_RESET:
                begin
                    phase_next = PH_RLOW;
                end
                owbm_pkg::FUNC_WRITE:
                begin
                    shift_next = tx_byte;
                    phase_next = PH_WSTART;
                end
                default:
                begin
                    shift_next = '0;
                    phase_next = PH_RSTART;
                end
            endcase
        end
    end

    always_comb
    begin
        case (phase_next)
            PH_RLOW, PH_WSTART, PH_RSTART: res.drive_low = 1'b1;
            PH_WHOLD:                      res.drive_low = ~shift_next[0];
            default:                       res.drive_low = 1'b0;
        endcase
        res.busy_res = (phase_next != PH_IDLE);
        res.done_res = done;
        res.status   = status_next;
        res.rx_byte  = rx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            tick_reg   <= '0;
            bit_reg    <= '0;
            shift_reg  <= '0;
            status_reg <= owbm_pkg::STAT_OK;
            rx_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            status_reg <= status_next;
            rx_reg     <= rx_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/owbm_out_buf.sv
`default_nettype none

module owbm_out_buf
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire owbm_pkg::owbm_res_t push_data,
    output logic                     can_push,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output owbm_pkg::owbm_res_t      out_data
);

    // Output register plus one skid entry, so the input side can take one more
    // item while a finished item waits to be taken.
    owbm_pkg::owbm_res_t main_reg;
    owbm_pkg::owbm_res_t skid_reg;
    logic                main_valid_reg;
    logic                skid_valid_reg;
    logic                pop;

    assign can_push  = ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign pop       = main_valid_reg & out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (push)
            begin
                main_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire

### tb/owbm_checker.sv
`timescale 1ns / 1ps

module owbm_checker
    import owbm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    owbm_cmd_if                    cmd,
    owbm_res_if                    res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic              pready,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output int                     fail_count,
    output int                     pending_count
);

    typedef enum logic [3:0] {
        S_IDLE      = 4'd0,
        S_RST_LOW   = 4'd1,
        S_RST_REL   = 4'd2,
        S_PRES_LOW  = 4'd3,
        S_PRES_HIGH = 4'd4,
        S_WR_START  = 4'd5,
        S_WR_HOLD   = 4'd6,
        S_WR_GAP    = 4'd7,
        S_RD_START  = 4'd8,
        S_RD_WAIT   = 4'd9,
        S_RD_REC    = 4'd10
    } line_phase_t;

    line_phase_t             phase_q;
    logic [COUNTER_BITS-1:0] tick_cnt;
    logic [2:0]              bit_pos;
    logic [7:0]              shreg;
    logic [1:0]              stat_reg;
    logic [7:0]              rx_hold;
    bit                      op_done;
    logic [CFG_W-1:0]        timing [CFG_NUM];
    owbm_res_t               awaited_results [$];
    int                      result_no;

    function automatic void enter(input line_phase_t p);
        phase_q  = p;
        tick_cnt = '0;
    endfunction

    // A limit of zero is met on the first tick, so it behaves as one.
    function automatic bit count_reached(input logic [CFG_W-1:0] lim);
        if (tick_cnt != CNT_MAX)
            tick_cnt = tick_cnt + 1'b1;
        return (tick_cnt >= lim) || (tick_cnt == CNT_MAX);
    endfunction

    function automatic void close_op(input logic [1:0] code);
        stat_reg = code;
        op_done  = 1'b1;
        enter(S_IDLE);
    endfunction

    function automatic owbm_res_t predict_line_result(input logic [1:0] func,
                                                      input logic [7:0] tx,
                                                      input logic       bus);
        owbm_res_t r;
        op_done = 1'b0;
        if (func == FUNC_TICK)
        begin
            case (phase_q)
                S_IDLE: ;
                S_RST_LOW:
                    if (count_reached(timing[REG_RESET_LOW]))
                        enter(S_RST_REL);
                S_RST_REL:
                    if (count_reached(timing[REG_RESET_RELEASE]))
                        enter(S_PRES_LOW);
                S_PRES_LOW:
                    if (!bus)
                        enter(S_PRES_HIGH);
                    else if (count_reached(timing[REG_PRESENCE]))
                        close_op(STAT_NO_PRESENCE);
                S_PRES_HIGH:
                    if (bus)
                        close_op(STAT_OK);
                    else if (count_reached(timing[REG_PRESENCE]))
                        close_op(STAT_NO_RELEASE);
                S_WR_START:
                    if (count_reached(timing[REG_SLOT_START]))
                        enter(S_WR_HOLD);
                S_WR_HOLD:
                    if (count_reached(timing[REG_WRITE_HOLD]))
                        enter(S_WR_GAP);
                S_WR_GAP:
                    if (count_reached(timing[REG_SLOT_START]))
                    begin
                        shreg = shreg >> 1;
                        if (bit_pos == 3'd7)
                            close_op(STAT_OK);
                        else
                        begin
                            bit_pos = bit_pos + 1'b1;
                            enter(S_WR_START);
                        end
                    end
                S_RD_START:
                    if (count_reached(timing[REG_SLOT_START]))
                        enter(S_RD_WAIT);
                S_RD_WAIT:
                    if (count_reached(timing[REG_READ_SAMPLE]))
                    begin
                        shreg = {bus, shreg[7:1]};
                        enter(S_RD_REC);
                    end
                S_RD_REC:
                    if (count_reached(timing[REG_READ_RECOVERY]))
                    begin
                        if (bit_pos == 3'd7)
                        begin
                            rx_hold = shreg;
                            close_op(STAT_OK);
                        end
                        else
                        begin
                            bit_pos = bit_pos + 1'b1;
                            enter(S_RD_START);
                        end
                    end
                default: enter(S_IDLE);
            endcase
        end
        else if (phase_q == S_IDLE)
        begin
            // Commands are only taken when idle; otherwise nothing changes.
            bit_pos = '0;
            case (func)
                FUNC_RESET: enter(S_RST_LOW);
                FUNC_WRITE:
                begin
                    shreg = tx;
                    enter(S_WR_START);
                end
                default:
                begin
                    shreg = '0;
                    enter(S_RD_START);
                end
            endcase
        end

        case (phase_q)
            S_RST_LOW, S_WR_START, S_RD_START: r.drive_low = 1'b1;
            S_WR_HOLD: r.drive_low = ~shreg[0];
            default: r.drive_low = 1'b0;
        endcase
        r.busy_res = (phase_q != S_IDLE);
        r.done_res = op_done;
        r.status   = stat_reg;
        r.rx_byte  = rx_hold;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("result %0d: %s is %0d, expected %0d", result_no, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        owbm_res_t want;
        if (!rst_n)
        begin
            phase_q  = S_IDLE;
            tick_cnt = '0;
            bit_pos  = '0;
            shreg    = '0;
            stat_reg = STAT_OK;
            rx_hold  = '0;
            op_done  = 1'b0;
            timing[REG_RESET_LOW]     = RST_RESET_LOW;
            timing[REG_RESET_RELEASE] = RST_RESET_RELEASE;
            timing[REG_PRESENCE]      = RST_PRESENCE;
            timing[REG_SLOT_START]    = RST_SLOT_START;
            timing[REG_WRITE_HOLD]    = RST_WRITE_HOLD;
            timing[REG_READ_SAMPLE]   = RST_READ_SAMPLE;
            timing[REG_READ_RECOVERY] = RST_READ_RECOVERY;
            awaited_results.delete();
            result_no     = 0;
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            // The output is registered, so a result leaving at this edge never
            // belongs to the item entering at it: compare first, then predict.
            if (res.valid && res.ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with nothing awaited", 1, 0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (res.drive_low !== want.drive_low)
                        report_mismatch("drive_low", res.drive_low, want.drive_low);
                    if (res.busy_res !== want.busy_res)
                        report_mismatch("busy_res", res.busy_res, want.busy_res);
                    if (res.done_res !== want.done_res)
                        report_mismatch("done_res", res.done_res, want.done_res);
                    if (res.status !== want.status)
                        report_mismatch("status", res.status, want.status);
                    if (res.rx_byte !== want.rx_byte)
                        report_mismatch("rx_byte", res.rx_byte, want.rx_byte);
                end
                result_no++;
            end
            if (cmd.valid && cmd.ready)
                awaited_results.push_back(predict_line_result(cmd.func, cmd.tx_byte,
                                                              cmd.bus_sample));
            if (psel && penable && pwrite && pready && int'(paddr[4:2]) < CFG_NUM)
                timing[paddr[4:2]] = pwdata[CFG_W-1:0];
            pending_count = awaited_results.size();
        end
    end

endmodule

### tb/tb_one_wire_bus_master.sv
`timescale 1ns / 1ps

module tb_one_wire_bus_master;
    import owbm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 850;

    typedef enum int {
        BUS_PRESENCE,
        BUS_HIGH,
        BUS_STUCK_LOW,
        BUS_NOISE
    } bus_mode_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    owbm_cmd_if cmd_if ();
    owbm_res_if res_if ();

    int               fail_count;
    int               pending_count;
    logic             last_busy;
    int               idle_cycles;
    int               gap_odds;
    int               stall_odds;
    bit               calm_tail;
    int               counted;
    logic [CFG_W-1:0] cfg_now [CFG_NUM];

    one_wire_bus_master u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_if),
        .res     (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    owbm_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_if),
        .res           (res_if),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The busy flag of the newest result tells whether the engine is idle
    // once nothing is outstanding.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_busy <= 1'b0;
        else if (res_if.valid && res_if.ready)
            last_busy <= res_if.busy_res;
    end

    // Every accepted input item counts towards the length of the run.
    always @(posedge clk)
    begin
        if (!rst_n)
            counted <= 0;
        else if (cmd_if.valid && cmd_if.ready)
            counted <= counted + 1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)
            || (psel && penable && pready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("one_wire_bus_master verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && !calm_tail && stall_odds != 0 && $urandom_range(0, stall_odds) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            res_if.ready <= 1'b1;
        end
    end

    function automatic int ticks_of(input logic [CFG_W-1:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [1:0] pick_command();
        case ($urandom_range(0, 2))
            0: return FUNC_RESET;
            1: return FUNC_WRITE;
            default: return FUNC_READ;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_timing();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 10'd1;
            default: return CFG_W'($urandom_range(1, 6));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer_item(input logic [1:0] func, input logic [7:0] tx, input logic lvl);
        cmd_if.valid      <= 1'b1;
        cmd_if.func       <= func;
        cmd_if.tx_byte    <= tx;
        cmd_if.bus_sample <= lvl;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic sender_gap();
        if (!calm_tail && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
    endtask

    task automatic hold_until_drained();
        cmd_if.valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_now[idx] = value;
        @(negedge clk);
    endtask

    // Ticks are sent until every result is back and the last one shows idle.
    // The line level follows the chosen pattern, counted in ticks from the
    // command, so that presence pulses land on the detection window.
    task automatic tick_until_idle(input bus_mode_t mode, input int pre, input int d,
                                   input int w);
        int   k;
        logic lvl;
        bit   idle_seen;
        k         = 0;
        idle_seen = 1'b0;
        while (!idle_seen)
        begin
            // An idle flag may be stale while items are outstanding, so drain
            // first and look again at the newest result.
            if (!last_busy)
            begin
                hold_until_drained();
                idle_seen = !last_busy;
            end
            if (!idle_seen)
            begin
                k++;
                sender_gap();
                if (!calm_tail && $urandom_range(0, 199) == 0)
                    hold_until_drained();
                if ($urandom_range(0, 29) == 0)
                    offer_item(pick_command(), pick_byte(), 1'($urandom_range(0, 1)));
                case (mode)
                    BUS_PRESENCE: lvl = (k > pre + d && k <= pre + d + 1 + w) ? 1'b0 : 1'b1;
                    BUS_HIGH:     lvl = 1'b1;
                    BUS_STUCK_LOW: lvl = (k > pre + d) ? 1'b0 : 1'b1;
                    default:      lvl = 1'($urandom_range(0, 1));
                endcase
                offer_item(FUNC_TICK, pick_byte(), lvl);
            end
        end
    endtask

    task automatic run_op(input logic [1:0] func, input bus_mode_t mode);
        int lim;
        int pre;
        int d;
        int w;
        lim = ticks_of(cfg_now[REG_PRESENCE]);
        pre = ticks_of(cfg_now[REG_RESET_LOW]) + ticks_of(cfg_now[REG_RESET_RELEASE]);
        d   = $urandom_range(0, (lim < 20) ? lim + 1 : 20);
        w   = $urandom_range(0, (lim < 20) ? lim + 1 : 20);
        sender_gap();
        offer_item(func, pick_byte(), 1'($urandom_range(0, 1)));
        tick_until_idle(mode, pre, d, w);
    endtask

    initial
    begin
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        cmd_if.valid         = 1'b0;
        cmd_if.func          = FUNC_TICK;
        cmd_if.tx_byte       = '0;
        cmd_if.bus_sample    = 1'b1;
        gap_odds             = 0;
        stall_odds           = 0;
        calm_tail            = 1'b0;
        cfg_now[REG_RESET_LOW]     = RST_RESET_LOW;
        cfg_now[REG_RESET_RELEASE] = RST_RESET_RELEASE;
        cfg_now[REG_PRESENCE]      = RST_PRESENCE;
        cfg_now[REG_SLOT_START]    = RST_SLOT_START;
        cfg_now[REG_WRITE_HOLD]    = RST_WRITE_HOLD;
        cfg_now[REG_READ_SAMPLE]   = RST_READ_SAMPLE;
        cfg_now[REG_READ_RECOVERY] = RST_READ_RECOVERY;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Short timings, with zeros that must act as one.
        write_reg(REG_RESET_LOW, 10'd1);
        write_reg(REG_RESET_RELEASE, 10'd0);
        write_reg(REG_PRESENCE, 10'd2);
        write_reg(REG_SLOT_START, 10'd1);
        write_reg(REG_WRITE_HOLD, 10'd0);
        write_reg(REG_READ_SAMPLE, 10'd1);
        write_reg(REG_READ_RECOVERY, 10'd1);

        // Ticks while idle change nothing.
        offer_item(FUNC_TICK, 8'h00, 1'b0);
        offer_item(FUNC_TICK, 8'hFF, 1'b1);
        // Reset with a good presence pulse; the write in between is ignored.
        offer_item(FUNC_RESET, 8'h00, 1'b1);
        offer_item(FUNC_WRITE, 8'hFF, 1'b0);
        offer_item(FUNC_TICK, 8'h00, 1'b1);
        offer_item(FUNC_TICK, 8'h00, 1'b1);
        offer_item(FUNC_TICK, 8'h00, 1'b0);
        offer_item(FUNC_TICK, 8'h00, 1'b0);
        offer_item(FUNC_TICK, 8'h00, 1'b1);
        // No device answers.
        offer_item(FUNC_RESET, 8'hFF, 1'b1);
        offer_item(FUNC_TICK, 8'h00, 1'b1);
        offer_item(FUNC_TICK, 8'h00, 1'b1);
        offer_item(FUNC_TICK, 8'h00, 1'b1);
        offer_item(FUNC_TICK, 8'h00, 1'b1);
        // The line is pulled low and never released.
        offer_item(FUNC_RESET, 8'h00, 1'b1);
        offer_item(FUNC_TICK, 8'h00, 1'b1);
        offer_item(FUNC_TICK, 8'h00, 1'b1);
        offer_item(FUNC_TICK, 8'h00, 1'b0);
        offer_item(FUNC_TICK, 8'h00, 1'b0);
        offer_item(FUNC_TICK, 8'h00, 1'b0);
        // A byte write with a read command arriving while it runs.
        offer_item(FUNC_WRITE, 8'h00, 1'b1);
        offer_item(FUNC_READ, 8'hA5, 1'b0);
        tick_until_idle(BUS_NOISE, 0, 0, 0);
        hold_until_drained();

        // Longer timings, with the presence window at its widest.
        gap_odds   = 7;
        stall_odds = 7;
        write_reg(REG_RESET_LOW, 10'd40);
        write_reg(REG_RESET_RELEASE, 10'd1);
        write_reg(REG_PRESENCE, 10'd1023);
        run_op(FUNC_RESET, BUS_PRESENCE);
        hold_until_drained();
        write_reg(REG_PRESENCE, 10'd30);
        run_op(FUNC_RESET, BUS_HIGH);
        run_op(FUNC_RESET, BUS_STUCK_LOW);
        hold_until_drained();
        write_reg(REG_RESET_LOW, 10'd2);
        write_reg(REG_SLOT_START, 10'd1);
        write_reg(REG_WRITE_HOLD, 10'd9);
        write_reg(REG_READ_SAMPLE, 10'd7);
        write_reg(REG_READ_RECOVERY, 10'd5);
        run_op(FUNC_WRITE, BUS_NOISE);
        run_op(FUNC_READ, BUS_NOISE);

        while (counted < ITEM_TARGET)
        begin
            calm_tail = (counted >= ITEM_TARGET - 150);
            case ($urandom_range(0, 2))
                0: gap_odds = 0;
                1: gap_odds = 3;
                default: gap_odds = 15;
            endcase
            case ($urandom_range(0, 2))
                0: stall_odds = 0;
                1: stall_odds = 3;
                default: stall_odds = 15;
            endcase
            hold_until_drained();
            for (int i = 0; i < CFG_NUM; i++)
                write_reg(reg_idx_t'(i), rand_timing());
            repeat ($urandom_range(2, 4))
                if (counted < ITEM_TARGET)
                    run_op(pick_command(), bus_mode_t'($urandom_range(0, 3)));
        end

        hold_until_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("one_wire_bus_master verification clean");
        else
            $display("one_wire_bus_master verification failed");
        $finish;
    end

endmodule

### files.f
rtl/core/owbm_pkg.sv
rtl/core/owbm_ifs.sv
rtl/core/owbm_cfg_regs.sv
rtl/core/owbm_engine.sv
rtl/core/owbm_out_buf.sv
rtl/core/one_wire_bus_master.sv
tb/owbm_checker.sv
tb/tb_one_wire_bus_master.sv
